[src/ps2kst_pkg.sv]
package ps2kst_pkg;

  // Request codes carried by req_type.
  typedef enum logic [1:0] {
    REQ_EDGE      = 2'd0,
    REQ_TICK      = 2'd1,
    REQ_QUERY     = 2'd2,
    REQ_QUERY_CLR = 2'd3
  } req_t;

  localparam logic [3:0]  FRAME_BITS    = 4'd11;
  localparam logic [7:0]  BREAK_CODE    = 8'hF0;
  localparam logic [15:0] TIMEOUT_RESET = 16'd250;
  localparam logic [15:0] TICKS_MAX     = 16'hFFFF;

  // One input item as held in the input register.
  typedef struct packed {
    req_t       req;
    logic       data_bit;
    logic [7:0] key_index;
  } item_t;

  // Completed frame passed from the frame receiver to the key map.
  typedef struct packed {
    logic       done;
    logic [7:0] code;
  } frame_evt_t;

endpackage

[src/ps2kst_frame.sv]
module ps2kst_frame (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  ps2kst_pkg::item_t      item,
  input  logic                   cfg_wr_en,
  input  logic [15:0]            cfg_wr_data,
  output ps2kst_pkg::frame_evt_t evt
);

  logic [15:0] timeout_ticks;
  logic [3:0]  bit_count;
  logic [3:0]  bit_count_next;
  logic [7:0]  shift_byte;
  logic [7:0]  shift_byte_next;
  logic [15:0] elapsed_ticks;
  logic [15:0] elapsed_ticks_next;

  logic        timed_out;
  logic [3:0]  count_start;
  logic [7:0]  byte_start;
  logic [7:0]  byte_shifted;
  logic [3:0]  count_inc;
  logic [2:0]  bit_pos;
  logic        is_edge;
  logic        is_tick;

  assign is_edge = (item.req == ps2kst_pkg::REQ_EDGE);
  assign is_tick = (item.req == ps2kst_pkg::REQ_TICK);

  // A long gap since the previous edge drops the partial frame.
  assign timed_out   = (elapsed_ticks > timeout_ticks);
  assign count_start = timed_out ? 4'd0 : bit_count;
  assign byte_start  = timed_out ? 8'd0 : shift_byte;

  // Data bits arrive on edges two to nine, least significant bit first.
  assign bit_pos = 3'(count_start - 4'd1);
  always_comb begin
    byte_shifted = byte_start;
    if (count_start >= 4'd1 && count_start <= 4'd8) begin
      byte_shifted = byte_start | (8'(item.data_bit) << bit_pos);
    end
  end
  assign count_inc = count_start + 4'd1;

  // Next state for edges and ticks; queries leave the receiver alone.
  always_comb begin
    bit_count_next     = bit_count;
    shift_byte_next    = shift_byte;
    elapsed_ticks_next = elapsed_ticks;
    evt.done           = 1'b0;
    evt.code           = 8'd0;
    if (is_edge) begin
      elapsed_ticks_next = 16'd0;
      if (count_inc == ps2kst_pkg::FRAME_BITS) begin
        evt.done        = 1'b1;
        evt.code        = byte_shifted;
        bit_count_next  = 4'd0;
        shift_byte_next = 8'd0;
      end else begin
        bit_count_next  = count_inc;
        shift_byte_next = byte_shifted;
      end
    end else if (is_tick) begin
      if (elapsed_ticks != ps2kst_pkg::TICKS_MAX) begin
        elapsed_ticks_next = elapsed_ticks + 16'd1;
      end
    end
  end

  // Receiver state and timeout register.
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= ps2kst_pkg::TIMEOUT_RESET;
      bit_count     <= 4'd0;
      shift_byte    <= 8'd0;
      elapsed_ticks <= 16'd0;
    end else begin
      if (cfg_wr_en) begin
        timeout_ticks <= cfg_wr_data;
      end
      if (fire) begin
        bit_count     <= bit_count_next;
        shift_byte    <= shift_byte_next;
        elapsed_ticks <= elapsed_ticks_next;
      end
    end
  end

endmodule

[src/ps2kst_keymap.sv]
module ps2kst_keymap (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  ps2kst_pkg::item_t      item,
  input  ps2kst_pkg::frame_evt_t evt,
  output logic                   key_pressed
);

  logic [255:0] pressed_map;
  logic [255:0] pressed_map_next;
  logic         break_pending;
  logic         break_pending_next;
  logic         is_query;
  logic         code_pressed;

  assign is_query     = (item.req == ps2kst_pkg::REQ_QUERY) ||
                        (item.req == ps2kst_pkg::REQ_QUERY_CLR);
  assign code_pressed = pressed_map[evt.code];
  assign key_pressed  = is_query ? pressed_map[item.key_index] : 1'b0;

  // Completed bytes press or release keys; a query may clear its key.
  always_comb begin
    pressed_map_next   = pressed_map;
    break_pending_next = break_pending;
    if (evt.done) begin
      if (break_pending) begin
        if (code_pressed) begin
          pressed_map_next[evt.code] = 1'b0;
        end else begin
          pressed_map_next = '0;
        end
      end else begin
        pressed_map_next[evt.code] = 1'b1;
      end
      break_pending_next = (evt.code == ps2kst_pkg::BREAK_CODE);
    end else if (item.req == ps2kst_pkg::REQ_QUERY_CLR) begin
      pressed_map_next[item.key_index] = 1'b0;
    end
  end

  // Key map flops clear in parallel at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      pressed_map   <= '0;
      break_pending <= 1'b0;
    end else if (fire) begin
      pressed_map   <= pressed_map_next;
      break_pending <= break_pending_next;
    end
  end

endmodule

[src/ps2_key_state_tracker_core.sv]
// Channel  | Handshake            | Payload
// ---------+----------------------+----------------------------------------
// in       | in_valid / in_stall  | req_type, data_bit, key_index
// out      | out_valid / out_stall| key_pressed, frame_done, frame_byte
// cfg      | cfg_wr_en            | cfg_wr_data (timeout_ticks)
//
// One item per cycle is sustained while out_stall is low; each item is held in the
// input register and then moves on into the result register.
// The pressed map and break flag update in that same pass, so one item's
// effect is visible to the very next item.
// Reset clears the valid flags, receiver state, break flag and the whole 256-key map.
// A stall on the output holds the result and then backs up into in_stall.
module ps2_key_state_tracker_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic        data_bit,
  input  logic [7:0]  key_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        key_pressed,
  output logic        frame_done,
  output logic [7:0]  frame_byte,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  ps2kst_pkg::item_t      in_item;
  logic                   in_item_valid;
  logic                   advance;
  logic                   in_accept;
  ps2kst_pkg::frame_evt_t evt;
  logic                   pressed_bit;

  // The held item moves on whenever the result register is free or draining.
  assign advance   = in_item_valid && (!out_valid || !out_stall);
  assign in_stall  = in_item_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_item_valid <= 1'b0;
    end else if (in_accept) begin
      in_item_valid <= 1'b1;
    end else if (advance) begin
      in_item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_item.req       <= ps2kst_pkg::req_t'(req_type);
      in_item.data_bit  <= data_bit;
      in_item.key_index <= key_index;
    end
  end

  ps2kst_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .fire        (advance),
    .item        (in_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .evt         (evt)
  );

  ps2kst_keymap u_keymap (
    .clk         (clk),
    .rst         (rst),
    .fire        (advance),
    .item        (in_item),
    .evt         (evt),
    .key_pressed (pressed_bit)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      key_pressed <= pressed_bit;
      frame_done  <= evt.done;
      frame_byte  <= evt.code;
    end
  end

endmodule

[src/ps2kst_checker.sv]
module ps2kst_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       key_pressed,
  input logic       frame_done,
  input logic [7:0] frame_byte
);

  // Reset empties the result register.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present right after reset");

  // A stalled result stays in place.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  // With no result waiting the block never stalls its input.
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while result register empty");

  // An edge result never reports a pressed key.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> !key_pressed)
    else $error("frame result carries a pressed bit");

  // The byte is zero unless a frame completed.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_done |-> frame_byte == 8'd0)
    else $error("frame byte set without a completed frame");

endmodule

bind ps2_key_state_tracker_core ps2kst_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .key_pressed (key_pressed),
  .frame_done  (frame_done),
  .frame_byte  (frame_byte)
);
